### rtl/gpg_pkg.sv
package gpg_pkg;

   localparam int FRAC_BITS_DEF = 31;
   localparam int CSR_W = 16;
   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 4;
   localparam logic [26:0] LN2_Q27 = 27'd93032640;
   localparam logic [15:0] SCALE_RESET = 16'd256;

   typedef enum logic [0:0] {
      CSR_MEAN  = 1'b0,
      CSR_SCALE = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic [31:0] uniform_a;
      logic [31:0] uniform_b;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] sample;
      logic               last;
   } rsp_word_type;

   typedef struct packed {
      logic        neg1;
      logic        neg2;
      logic [30:0] mag1;
      logic [30:0] mag2;
   } ctx_type;

   typedef struct packed {
      ctx_type     ctx;
      logic [61:0] v;
   } mid_word_type;

   typedef struct packed {
      logic signed [31:0] sample_a;
      logic signed [31:0] sample_b;
   } pair_type;

   typedef struct packed {
      logic signed [15:0] mean;
      logic [15:0]        scale;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

endpackage

### rtl/gpg_fifo.sv
module gpg_fifo import gpg_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = MID_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic [WIDTH-1:0]   wr_data,
   input  logic               pop,
   output logic [WIDTH-1:0]   rd_data,
   output fifo_stat_type      stat
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [AW-1:0]    wp_ff;
   logic [AW-1:0]    rp_ff;
   logic [CW-1:0]    cnt_ff;
   logic [AW-1:0]    wp_in;
   logic [AW-1:0]    rp_in;

   assign wp_in = (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
   assign rp_in = (rp_ff == AW'(DEPTH - 1)) ? '0 : rp_ff + 1'b1;

   assign stat.full  = (cnt_ff == CW'(DEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign rd_data    = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= wp_in;
         end
         if (pop) begin
            rp_ff <= rp_in;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !stat.full) else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !stat.empty) else $error("pop from empty queue");

endmodule

### rtl/gpg_front.sv
module gpg_front import gpg_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_push,
   input  req_word_type  req_word,
   output logic          req_full,
   output logic          mid_push,
   output mid_word_type  mid_word,
   input  fifo_stat_type mid_stat
);

   localparam int SHR = 31 - FRAC_BITS;
   localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

   logic        adv;
   logic        keep;
   logic [31:0] u1;
   logic [31:0] u2;

   logic        va_ff, vb_ff, vc_ff;
   logic        na1_ff, na2_ff, nb1_ff, nb2_ff, nc1_ff, nc2_ff;
   logic [31:0] ma1_ff, ma2_ff;
   logic [30:0] mb1_ff, mb2_ff, mc1_ff, mc2_ff;
   logic [63:0] sq1_ff, sq2_ff;
   logic [63:0] wc_ff;

   assign u1 = req_word.uniform_a >> SHR;
   assign u2 = req_word.uniform_b >> SHR;

   assign keep     = (wc_ff != '0) && ((wc_ff >> (2 * FRAC_BITS)) == '0);
   assign adv      = !(vc_ff && keep && mid_stat.full);
   assign req_full = !adv;
   assign mid_push = vc_ff && keep && !mid_stat.full;

   assign mid_word.ctx.neg1 = nc1_ff;
   assign mid_word.ctx.neg2 = nc2_ff;
   assign mid_word.ctx.mag1 = mc1_ff;
   assign mid_word.ctx.mag2 = mc2_ff;
   assign mid_word.v        = 62'(wc_ff << (62 - 2 * FRAC_BITS));

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (adv) begin
         va_ff <= req_push;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         na1_ff <= !u1[FRAC_BITS];
         na2_ff <= !u2[FRAC_BITS];
         ma1_ff <= u1[FRAC_BITS] ? (u1 - ONE) : (ONE - u1);
         ma2_ff <= u2[FRAC_BITS] ? (u2 - ONE) : (ONE - u2);
         nb1_ff <= na1_ff;
         nb2_ff <= na2_ff;
         mb1_ff <= ma1_ff[30:0];
         mb2_ff <= ma2_ff[30:0];
         sq1_ff <= ma1_ff * ma1_ff;
         sq2_ff <= ma2_ff * ma2_ff;
         nc1_ff <= nb1_ff;
         nc2_ff <= nb2_ff;
         mc1_ff <= mb1_ff;
         mc2_ff <= mb2_ff;
         wc_ff  <= sq1_ff + sq2_ff;
      end
   end

endmodule

### rtl/gpg_back.sv
module gpg_back import gpg_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  fifo_stat_type mid_stat,
   input  mid_word_type  mid_word,
   output logic          mid_pop,
   input  fifo_stat_type out_stat,
   output logic          out_push,
   output pair_type      out_word
);

   localparam int NRM_N  = 6;
   localparam int ST_LOG = 7;
   localparam int LOG_N  = 30;
   localparam int ST_LG  = 38;
   localparam int ST_DIV = 39;
   localparam int DIV_N  = 33;
   localparam int ST_SQ  = 72;
   localparam int SQ_N   = 29;
   localparam int ST_SH  = 102;
   localparam int ST_SCL = 104;
   localparam int LAST   = 105;

   logic    adv;
   logic    vld_ff [0:LAST];
   ctx_type ctx_ff [0:ST_SCL];

   assign adv      = !(vld_ff[LAST] && out_stat.full);
   assign mid_pop  = adv && !mid_stat.empty;
   assign out_push = vld_ff[LAST] && !out_stat.full;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= !mid_stat.empty;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctx_ff[0] <= mid_word.ctx;
      end
   end

   for (genvar s = 1; s <= LAST; s++) begin : g_vld
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (adv) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   for (genvar s = 1; s <= ST_SCL; s++) begin : g_ctx
      always_ff @(posedge clock) begin
         if (adv) begin
            ctx_ff[s] <= ctx_ff[s-1];
         end
      end
   end

   // leading-one normalize
   logic [61:0] nv_ff [0:NRM_N];
   logic [5:0]  nk_ff [0:NRM_N];

   always_ff @(posedge clock) begin
      if (adv) begin
         nv_ff[0] <= mid_word.v;
         nk_ff[0] <= '0;
      end
   end

   for (genvar s = 0; s < NRM_N; s++) begin : g_nrm
      localparam int SH = 32 >> s;
      always_ff @(posedge clock) begin
         if (adv) begin
            if (nv_ff[s][61 -: SH] == '0) begin
               nv_ff[s+1] <= nv_ff[s] << SH;
               nk_ff[s+1] <= nk_ff[s] + 6'(SH);
            end else begin
               nv_ff[s+1] <= nv_ff[s];
               nk_ff[s+1] <= nk_ff[s];
            end
         end
      end
   end

   // log2 by repeated squaring
   logic [30:0] lz_ff  [0:LOG_N];
   logic [29:0] lf_ff  [0:LOG_N];
   logic [5:0]  lip_ff [0:LOG_N];
   logic [31:0] mm_ff  [ST_LOG:ST_SQ-1];
   logic [4:0]  hh_ff  [ST_LOG:ST_SH-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         lz_ff[0]      <= nv_ff[NRM_N][61:31];
         lf_ff[0]      <= '0;
         lip_ff[0]     <= nk_ff[NRM_N] + 6'd1;
         mm_ff[ST_LOG] <= nk_ff[NRM_N][0] ? {1'b0, nv_ff[NRM_N][61:31]}
                                          : nv_ff[NRM_N][61:30];
         hh_ff[ST_LOG] <= nk_ff[NRM_N][5:1];
      end
   end

   for (genvar s = ST_LOG + 1; s < ST_SQ; s++) begin : g_mm
      always_ff @(posedge clock) begin
         if (adv) begin
            mm_ff[s] <= mm_ff[s-1];
         end
      end
   end

   for (genvar s = ST_LOG + 1; s < ST_SH; s++) begin : g_hh
      always_ff @(posedge clock) begin
         if (adv) begin
            hh_ff[s] <= hh_ff[s-1];
         end
      end
   end

   for (genvar i = 0; i < LOG_N; i++) begin : g_log
      logic [61:0] sq;
      logic [31:0] t;
      assign sq = lz_ff[i] * lz_ff[i];
      assign t  = sq[61:30];
      always_ff @(posedge clock) begin
         if (adv) begin
            lz_ff[i+1]  <= t[31] ? t[31:1] : t[30:0];
            lf_ff[i+1]  <= {lf_ff[i][28:0], t[31]};
            lip_ff[i+1] <= lip_ff[i];
         end
      end
   end

   logic [35:0] lg_ff;
   logic [62:0] np;
   logic        dnb_ff;
   logic [31:0] dr_ff [0:DIV_N-1];
   logic [32:0] dq_ff [0:DIV_N];

   assign np = lg_ff * LN2_Q27;

   always_ff @(posedge clock) begin
      if (adv) begin
         lg_ff    <= {lip_ff[LOG_N], 30'd0} - {6'd0, lf_ff[LOG_N]};
         dr_ff[0] <= {2'b00, np[62:33]};
         dnb_ff   <= np[32];
         dq_ff[0] <= '0;
      end
   end

   // restoring divide, one quotient bit per stage
   for (genvar j = 0; j < DIV_N; j++) begin : g_div
      logic [32:0] r;
      logic [33:0] dif;
      assign r   = {dr_ff[j], (j == 0) ? dnb_ff : 1'b0};
      assign dif = {1'b0, r} - {2'b00, mm_ff[ST_DIV+j]};
      always_ff @(posedge clock) begin
         if (adv) begin
            dq_ff[j+1] <= {dq_ff[j][31:0], !dif[33]};
         end
      end
      if (j < DIV_N - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (adv) begin
               dr_ff[j+1] <= dif[33] ? r[31:0] : dif[31:0];
            end
         end
      end
   end

   // digit-by-digit square root
   logic [28:0] sr_ff [1:SQ_N];
   logic [30:0] se_ff [1:SQ_N-1];
   logic [57:0] so_ff [1:SQ_N-1];

   for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
      logic [28:0] root;
      logic [30:0] rem;
      logic [57:0] op;
      logic [32:0] r;
      logic [32:0] trial;
      logic [33:0] dif;
      if (i == 0) begin : g_first
         assign root = '0;
         assign rem  = '0;
         assign op   = {1'b0, dq_ff[DIV_N], 24'd0};
      end else begin : g_next
         assign root = sr_ff[i];
         assign rem  = se_ff[i];
         assign op   = so_ff[i];
      end
      assign r     = {rem, op[57:56]};
      assign trial = {2'b00, root, 2'b01};
      assign dif   = {1'b0, r} - {1'b0, trial};
      always_ff @(posedge clock) begin
         if (adv) begin
            sr_ff[i+1] <= {root[27:0], !dif[33]};
         end
      end
      if (i < SQ_N - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (adv) begin
               se_ff[i+1] <= dif[33] ? r[30:0] : dif[30:0];
               so_ff[i+1] <= op << 2;
            end
         end
      end
   end

   // scale and offset
   logic [30:0] sa1_ff, sa2_ff;
   logic [28:0] ss_ff;
   logic [59:0] pp1_ff, pp2_ff;
   logic [29:0] gm1, gm2;
   logic [45:0] sc1_ff, sc2_ff;
   logic [47:0] base;
   logic [47:0] sum1, sum2;
   pair_type    pair_ff;

   assign gm1  = 30'(pp1_ff >> FRAC_BITS);
   assign gm2  = 30'(pp2_ff >> FRAC_BITS);
   assign base = {{8{cfg.mean[15]}}, cfg.mean, 24'd0} | 48'h8000;
   assign sum1 = base + ({2'b00, sc1_ff} ^ {48{ctx_ff[ST_SCL].neg1}})
                      + {47'd0, ctx_ff[ST_SCL].neg1};
   assign sum2 = base + ({2'b00, sc2_ff} ^ {48{ctx_ff[ST_SCL].neg2}})
                      + {47'd0, ctx_ff[ST_SCL].neg2};

   always_ff @(posedge clock) begin
      if (adv) begin
         sa1_ff           <= 31'(ctx_ff[ST_SH-1].mag1 << hh_ff[ST_SH-1]);
         sa2_ff           <= 31'(ctx_ff[ST_SH-1].mag2 << hh_ff[ST_SH-1]);
         ss_ff            <= sr_ff[SQ_N];
         pp1_ff           <= sa1_ff * ss_ff;
         pp2_ff           <= sa2_ff * ss_ff;
         sc1_ff           <= gm1 * cfg.scale;
         sc2_ff           <= gm2 * cfg.scale;
         pair_ff.sample_a <= sum1[47:16];
         pair_ff.sample_b <= sum2[47:16];
      end
   end

   assign out_word = pair_ff;

endmodule

### rtl/gaussian_polar_generator.sv
// Normal variate generator, polar rejection method.
// Input queue (req_push / req_full): one word per accepted edge, holding two
// uniform 32-bit values. Pairs on or outside the unit circle, or at its
// center, are dropped and give no result. Others give two results on the
// output queue (rsp_empty / rsp_pop): sample for x1, then sample for x2 with
// last set. Samples are Q16.16: mean + x * sqrt(-2 ln w / w) * scale.
// Config (csr_we / csr_idx / csr_wdata): index 0 mean (signed Q8.8),
// index 1 scale (unsigned Q8.8); write only while no word is in flight.
// The second sample of a pair is shown in the cycle after the first is popped.
// Built from a 106-stage arithmetic pipe (normalize, 30 squaring steps,
// 33-bit divide, 29-step root, scaling), a 3-stage front end and two
// 4-word queues. Throughput: one input word per cycle while req_full is
// low; results leave one per cycle while rsp_pop is high and rsp_empty is
// low, two results per kept pair.
// Reset clears all queues and pipes, mean to 0 and scale to 1.0.
// When rsp_pop is held low, the output queue fills, the pipe freezes, the
// middle queue fills, and req_full rises; nothing is dropped.
module gaussian_polar_generator import gpg_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  req_word_type       req_word,
   output logic               req_full,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output rsp_word_type       rsp_word,
   input  logic               csr_we,
   input  logic [0:0]         csr_idx,
   input  logic [CSR_W-1:0]   csr_wdata
);

   logic signed [15:0] mean_ff;
   logic [15:0]        scale_ff;
   logic               ph_ff;
   cfg_type            cfg;

   logic               mid_push;
   logic               mid_pop;
   mid_word_type       mid_in;
   mid_word_type       mid_out;
   fifo_stat_type      mid_stat;

   logic               out_push;
   logic               out_pop;
   pair_type           out_in;
   pair_type           out_head;
   fifo_stat_type      out_stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff  <= '0;
         scale_ff <= SCALE_RESET;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_idx))
            CSR_MEAN:  mean_ff  <= csr_wdata;
            CSR_SCALE: scale_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg.mean  = mean_ff;
   assign cfg.scale = scale_ff;

   gpg_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_word (req_word),
      .req_full (req_full),
      .mid_push (mid_push),
      .mid_word (mid_in),
      .mid_stat (mid_stat)
   );

   gpg_fifo #(.WIDTH($bits(mid_word_type)), .DEPTH(MID_DEPTH)) u_mid (
      .clock   (clock),
      .reset   (reset),
      .push    (mid_push),
      .wr_data (mid_in),
      .pop     (mid_pop),
      .rd_data (mid_out),
      .stat    (mid_stat)
   );

   gpg_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .mid_stat (mid_stat),
      .mid_word (mid_out),
      .mid_pop  (mid_pop),
      .out_stat (out_stat),
      .out_push (out_push),
      .out_word (out_in)
   );

   gpg_fifo #(.WIDTH($bits(pair_type)), .DEPTH(OUT_DEPTH)) u_out (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data (out_in),
      .pop     (out_pop),
      .rd_data (out_head),
      .stat    (out_stat)
   );

   assign rsp_empty       = out_stat.empty;
   assign rsp_word.sample = ph_ff ? out_head.sample_b : out_head.sample_a;
   assign rsp_word.last   = ph_ff;
   assign out_pop         = rsp_pop && !rsp_empty && ph_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= 1'b0;
      end else if (rsp_pop && !rsp_empty) begin
         ph_ff <= !ph_ff;
      end
   end

   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && !rsp_word.last) |=> (!rsp_empty && rsp_word.last))
      else $error("second sample of pair missing");

   a_ready_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !req_full) else $error("input blocked after reset");

endmodule

### verif/tb_gaussian_polar_generator.sv
`timescale 1ns / 1ps

module tb_gaussian_polar_generator;
   import gpg_pkg::*;

   localparam int FB = FRAC_BITS_DEF;
   localparam int PIPE_WAIT = 150;
   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      logic [31:0] ua;
      logic [31:0] ub;
      int          n_words;  // -1: take count from predictor
   } pair_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_push = 1'b0;
   req_word_type req_word = '0;
   logic         req_full;
   logic         rsp_empty;
   logic         rsp_pop = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_we = 1'b0;
   logic [0:0]   csr_idx = CSR_MEAN;
   logic [15:0]  csr_wdata = '0;

   logic signed [15:0] mdl_mean = 16'sd0;
   logic [15:0]        mdl_scale = SCALE_RESET;
   rsp_word_type       sample_q[$];
   int                 n_errors = 0;
   int                 quiet_cycles = 0;
   int                 hold_start = 0;

   gaussian_polar_generator u_top (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_word (req_word),
      .req_full (req_full),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_word (rsp_word),
      .csr_we   (csr_we),
      .csr_idx  (csr_idx),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic longint unsigned isqrt_floor(input longint unsigned n_in);
      longint unsigned n, r, b;
      n = n_in;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic rsp_word_type scale_sample(input longint x, input int sh,
                                                 input longint unsigned s24,
                                                 input logic fin);
      longint unsigned ax, mag, scaled;
      longint          val, mn, r;
      rsp_word_type    o;
      ax = (x < 0) ? longint'(-x) : x;
      mag = ((ax << sh) * s24) >> FB;
      scaled = mag * longint'(mdl_scale);
      val = (x < 0) ? -longint'(scaled) : longint'(scaled);
      mn = mdl_mean;
      val = val + mn * 16777216;
      r = (val + 32768) >>> 16;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      o.sample = r[31:0];
      o.last = fin;
      return o;
   endfunction

   function automatic int gauss_pair(input logic [31:0] ua, input logic [31:0] ub,
                                     output rsp_word_type r0, output rsp_word_type r1);
      longint          x1, x2;
      longint unsigned w, v, vn, z, f, lg, m32, n24, q24, s24;
      int              p, sh;
      x1 = longint'({32'b0, ua} >> (31 - FB)) - (64'sd1 <<< FB);
      x2 = longint'({32'b0, ub} >> (31 - FB)) - (64'sd1 <<< FB);
      w = longint'(x1 * x1) + longint'(x2 * x2);
      r0 = '0;
      r1 = '0;
      if (w == 0 || w >= (64'd1 << (2 * FB))) return 0;
      v = w << (62 - 2 * FB);
      p = 61;
      while (p > 0 && v[p] == 1'b0) p--;
      z = (p >= 30) ? (v >> (p - 30)) : (v << (30 - p));
      f = 0;
      for (int i = 0; i < 30; i++) begin
         z = (z * z) >> 30;
         f = f << 1;
         if (z >= (64'd1 << 31)) begin
            f = f | 64'd1;
            z = z >> 1;
         end
      end
      lg = (longint'(62 - p) << 30) - f;
      vn = v;
      sh = 0;
      while (vn < (64'd1 << 60)) begin
         vn = vn << 2;
         sh++;
      end
      m32 = vn >> 30;
      n24 = (lg * 64'(LN2_Q27)) >> 32;
      q24 = (n24 << 32) / m32;
      s24 = isqrt_floor(q24 << 24);
      r0 = scale_sample(x1, sh, s24, 1'b0);
      r1 = scale_sample(x2, sh, s24, 1'b1);
      return 2;
   endfunction

   // expected samples, collected at the accepting edge
   always @(posedge clock) begin
      rsp_word_type e0, e1;
      if (!reset && req_push && !req_full) begin
         if (gauss_pair(req_word.uniform_a, req_word.uniform_b, e0, e1) == 2) begin
            sample_q.push_back(e0);
            sample_q.push_back(e1);
         end
      end
   end

   // result side: check, random stalls, and one long hold-off
   initial begin
      int stall_left;
      int hold_left;
      rsp_word_type e;
      stall_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            if (sample_q.size() == 0) begin
               $display("%0t: unexpected word sample=%0d last=%0b", $time,
                        rsp_word.sample, rsp_word.last);
               n_errors++;
            end else begin
               e = sample_q.pop_front();
               if (e.sample !== rsp_word.sample) begin
                  $display("%0t: sample expected %0d actual %0d", $time,
                           e.sample, rsp_word.sample);
                  n_errors++;
               end
               if (e.last !== rsp_word.last) begin
                  $display("%0t: last expected %0b actual %0b", $time,
                           e.last, rsp_word.last);
                  n_errors++;
               end
            end
         end
         if (hold_start != 0) begin
            hold_start = 0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else if ($urandom_range(0, 99) < 65) begin
            rsp_pop <= 1'b1;
         end else begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                     : $urandom_range(0, 3);
            rsp_pop <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_pair(input logic [31:0] ua, input logic [31:0] ub);
      int gap;
      req_push <= 1'b1;
      req_word <= '{uniform_a: ua, uniform_b: ub};
      @(posedge clock);
      while (req_full) @(posedge clock);
      gap = ($urandom_range(0, 2) != 0) ? 0 :
            (($urandom_range(0, 14) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3));
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_all();
      req_push <= 1'b0;
      while (sample_q.size() != 0) @(posedge clock);
      repeat (PIPE_WAIT) @(posedge clock);
   endtask

   task automatic csr_write(input csr_idx_type idx, input logic [15:0] val);
      csr_we <= 1'b1;
      csr_idx <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_MEAN) mdl_mean = val;
      else mdl_scale = val;
   endtask

   pair_row_type dir_rows[] = '{
      '{32'h8000_0000, 32'h8000_0000, 0},   // center of circle
      '{32'h0000_0000, 32'h8000_0000, 0},   // on the circle
      '{32'h8000_0000, 32'h0000_0000, 0},
      '{32'h0000_0000, 32'h0000_0000, 0},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 0},   // outside
      '{32'h0000_0001, 32'h8000_0000, -1},
      '{32'h8000_0001, 32'h8000_0000, -1},  // smallest w
      '{32'h8000_0000, 32'h8000_0001, -1},
      '{32'h7FFF_FFFF, 32'h8000_0000, -1},
      '{32'hFFFF_FFFF, 32'h8000_0000, -1},  // largest |x|
      '{32'h8000_0000, 32'hFFFF_FFFF, -1},
      '{32'hC000_0000, 32'h8000_0000, -1},
      '{32'h4000_0000, 32'hC000_0000, -1},
      '{32'hA000_0000, 32'h6000_0000, -1},
      '{32'h8000_0003, 32'h7FFF_FFFD, -1},
      '{32'h5555_5555, 32'hAAAA_AAAA, -1}
   };

   initial begin
      rsp_word_type d0, d1;
      logic [31:0] ua, ub;
      int n_pred;
      logic [15:0] ph_mean[5];
      logic [15:0] ph_scale[5];
      ph_mean = '{16'h0000, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000};
      ph_scale = '{16'h0100, 16'hFFFF, 16'h0000, 16'h0000, 16'h0100};
      ph_mean[3] = $urandom_range(0, 65535);
      ph_scale[3] = $urandom_range(0, 65535);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         n_pred = gauss_pair(dir_rows[i].ua, dir_rows[i].ub, d0, d1);
         if (dir_rows[i].n_words >= 0 && n_pred != dir_rows[i].n_words) begin
            $display("%0t: row %0d word count expected %0d actual %0d", $time, i,
                     dir_rows[i].n_words, n_pred);
            n_errors++;
         end
         send_pair(dir_rows[i].ua, dir_rows[i].ub);
      end
      drain_all();

      for (int ph = 0; ph < 5; ph++) begin
         csr_write(CSR_MEAN, ph_mean[ph]);
         csr_write(CSR_SCALE, ph_scale[ph]);
         for (int k = 0; k < 150; k++) begin
            if (ph == 1 && k == 10) hold_start = 1;
            ua = $urandom;
            ub = $urandom;
            case ($urandom_range(0, 19))
               0: ua = 32'h8000_0000 + $urandom_range(0, 3);
               1: ub = 32'h8000_0000 - $urandom_range(0, 3);
               2: ua = {ua[31], 31'h7FFF_FFFF};
               default: ;
            endcase
            send_pair(ua, ub);
         end
         drain_all();
      end

      if (n_errors == 0 && sample_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### sim.f
rtl/gpg_pkg.sv
rtl/gpg_fifo.sv
rtl/gpg_front.sv
rtl/gpg_back.sv
rtl/gaussian_polar_generator.sv
verif/tb_gaussian_polar_generator.sv
